// ===== hdl/jrs_pkg.sv =====
// Shared types, constants and character functions for the JSON record serializer.
// Used by jrs_ctrl, jrs_dp and json_record_serializer_core; depends on nothing.
package jrs_pkg;

  // Item kinds carried on the input tuser.
  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_NAME   = 2'd1;
  localparam logic [1:0] KIND_ENDREC = 2'd2;
  localparam logic [1:0] KIND_ENDARR = 2'd3;

  localparam int IN_DATA_W = 72;
  localparam int NUM_W     = 32;
  localparam int BCD_DIGITS = 10;
  localparam logic [5:0] CONV_STEPS = 6'd32;
  localparam logic [3:0] DIG_TOP = 4'd9;

  localparam logic [7:0] CH_OPEN   = 8'h5B;  // [
  localparam logic [7:0] CH_CLOSE  = 8'h5D;  // ]
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BRACE  = 8'h7D;  // }
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_U      = 8'h75;

  // All fixed fragments of a header, back to back.
  localparam int TXT_LEN = 41;
  localparam logic [TXT_LEN*8-1:0] TXT_ROM =
    "{\"id\":,\"flag\":truefalse,\"value\":,\"name\":\"";

  localparam logic [5:0] ROM_OBJ   = 6'd0;
  localparam logic [5:0] ROM_FLAG  = 6'd6;
  localparam logic [5:0] ROM_TRUE  = 6'd14;
  localparam logic [5:0] ROM_FALSE = 6'd18;
  localparam logic [5:0] ROM_VALUE = 6'd23;
  localparam logic [5:0] ROM_NAME  = 6'd32;

  typedef enum logic [1:0] {
    SRC_CHAR,
    SRC_ROM,
    SRC_DIGIT,
    SRC_ESC
  } src_e;

  typedef struct packed {
    logic       emit;
    src_e       src;
    logic [7:0] ch;
    logic       last;
    logic       latch;
    logic       esc_from_in;
    logic       esc_init;
    logic       esc_step;
    logic       rom_load;
    logic [5:0] rom_addr;
    logic       rom_step;
    logic       conv_start;
    logic       conv_sel_id;
    logic       dig_step;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic in_plain;
    logic rom_seg_end;
    logic conv_done;
    logic dig_skip;
    logic dig_last;
    logic esc_last;
    logic id_div3;
  } sts_t;

  function automatic logic [7:0] txt_byte(input logic [5:0] a);
    logic [7:0] b;
    b = 8'h00;
    if (int'(a) < TXT_LEN) begin
      b = TXT_ROM[(TXT_LEN - 1 - int'(a))*8 +: 8];
    end
    return b;
  endfunction

  function automatic logic is_seg_end(input logic [5:0] a);
    return (a == ROM_FLAG - 6'd1) || (a == ROM_TRUE - 6'd1) || (a == ROM_FALSE - 6'd1) ||
           (a == ROM_VALUE - 6'd1) || (a == ROM_NAME - 6'd1) ||
           (a == 6'(TXT_LEN - 1));
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] d);
    return (d < 4'd10) ? (8'h30 + {4'd0, d}) : (8'h57 + {4'd0, d});
  endfunction

  // Number of output bytes for one name byte: 1 plain, 2 short escape, 6 \u00xx.
  function automatic logic [2:0] esc_len(input logic [7:0] c);
    logic [2:0] n;
    case (c)
      CH_QUOTE, CH_BSLASH, 8'h08, 8'h0C, 8'h0A, 8'h0D, 8'h09: n = 3'd2;
      default: n = (c <= 8'h1F) ? 3'd6 : 3'd1;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] esc_code(input logic [7:0] c);
    logic [7:0] b;
    case (c)
      CH_QUOTE:  b = CH_QUOTE;
      CH_BSLASH: b = CH_BSLASH;
      8'h08:     b = "b";
      8'h0C:     b = "f";
      8'h0A:     b = "n";
      8'h0D:     b = "r";
      default:   b = "t";
    endcase
    return b;
  endfunction

  function automatic logic [7:0] esc_byte(input logic [7:0] c, input logic [2:0] idx);
    logic [2:0] n;
    logic [7:0] b;
    n = esc_len(c);
    if (idx == 3'd0) begin
      b = (n == 3'd1) ? c : CH_BSLASH;
    end else if (n == 3'd2) begin
      b = esc_code(c);
    end else begin
      case (idx)
        3'd1:       b = CH_U;
        3'd2, 3'd3: b = CH_ZERO;
        3'd4:       b = hex_char(c[7:4]);
        default:    b = hex_char(c[3:0]);
      endcase
    end
    return b;
  endfunction

endpackage

// ===== hdl/jrs_ctrl.sv =====
// Controller state machine of the JSON record serializer.
// Sequences the output bytes of each item; depends on jrs_pkg.
module jrs_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_tvalid_i,
  input  logic [1:0]    kind_i,
  output logic          s_tready_o,
  input  jrs_pkg::sts_t sts_i,
  output jrs_pkg::cmd_t cmd_o
);
  import jrs_pkg::*;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_OBJ    = 4'd1;
  localparam logic [3:0] ST_IDDIG  = 4'd2;
  localparam logic [3:0] ST_FLAG   = 4'd3;
  localparam logic [3:0] ST_BOOL   = 4'd4;
  localparam logic [3:0] ST_VAL    = 4'd5;
  localparam logic [3:0] ST_VALDIG = 4'd6;
  localparam logic [3:0] ST_NAME   = 4'd7;
  localparam logic [3:0] ST_ESC    = 4'd8;
  localparam logic [3:0] ST_ENDREC = 4'd9;
  localparam logic [3:0] ST_ENDARR = 4'd10;

  logic [3:0] state_q, state_d;
  logic       seen_q, seen_d;
  cmd_t       cmd;

  always_comb begin
    state_d    = state_q;
    seen_d     = seen_q;
    cmd        = '0;
    cmd.src    = SRC_CHAR;
    s_tready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_tready_o = sts_i.out_free;
        if (s_tvalid_i && sts_i.out_free) begin
          cmd.emit  = 1'b1;
          cmd.latch = 1'b1;
          case (kind_i)
            KIND_HEADER: begin
              cmd.ch          = seen_q ? CH_COMMA : CH_OPEN;
              cmd.rom_load    = 1'b1;
              cmd.rom_addr    = ROM_OBJ;
              cmd.conv_start  = 1'b1;
              cmd.conv_sel_id = 1'b1;
              seen_d          = 1'b1;
              state_d         = ST_OBJ;
            end
            KIND_NAME: begin
              cmd.src         = SRC_ESC;
              cmd.esc_from_in = 1'b1;
              cmd.esc_init    = 1'b1;
              cmd.last        = sts_i.in_plain;
              if (!sts_i.in_plain) begin
                state_d = ST_ESC;
              end
            end
            KIND_ENDREC: begin
              cmd.ch  = CH_QUOTE;
              state_d = ST_ENDREC;
            end
            default: begin
              if (seen_q) begin
                cmd.ch   = CH_CLOSE;
                cmd.last = 1'b1;
                seen_d   = 1'b0;
              end else begin
                cmd.ch  = CH_OPEN;
                state_d = ST_ENDARR;
              end
            end
          endcase
        end
      end
      ST_OBJ, ST_FLAG, ST_BOOL, ST_VAL, ST_NAME: begin
        if (sts_i.out_free) begin
          cmd.emit     = 1'b1;
          cmd.src      = SRC_ROM;
          cmd.rom_step = 1'b1;
          if (sts_i.rom_seg_end) begin
            case (state_q)
              ST_OBJ:  state_d = ST_IDDIG;
              ST_FLAG: begin
                cmd.rom_load = 1'b1;
                cmd.rom_addr = sts_i.id_div3 ? ROM_TRUE : ROM_FALSE;
                state_d      = ST_BOOL;
              end
              ST_BOOL: begin
                cmd.rom_load = 1'b1;
                cmd.rom_addr = ROM_VALUE;
                state_d      = ST_VAL;
              end
              ST_VAL:  state_d = ST_VALDIG;
              default: begin
                cmd.last = 1'b1;
                state_d  = ST_IDLE;
              end
            endcase
          end
        end
      end
      ST_IDDIG, ST_VALDIG: begin
        if (sts_i.conv_done) begin
          if (sts_i.dig_skip) begin
            cmd.dig_step = 1'b1;
          end else if (sts_i.out_free) begin
            cmd.emit     = 1'b1;
            cmd.src      = SRC_DIGIT;
            cmd.dig_step = 1'b1;
            if (sts_i.dig_last) begin
              cmd.rom_load = 1'b1;
              if (state_q == ST_IDDIG) begin
                cmd.rom_addr   = ROM_FLAG;
                cmd.conv_start = 1'b1;
                state_d        = ST_FLAG;
              end else begin
                cmd.rom_addr = ROM_NAME;
                state_d      = ST_NAME;
              end
            end
          end
        end
      end
      ST_ESC: begin
        if (sts_i.out_free) begin
          cmd.emit     = 1'b1;
          cmd.src      = SRC_ESC;
          cmd.esc_step = 1'b1;
          cmd.last     = sts_i.esc_last;
          if (sts_i.esc_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_ENDREC, ST_ENDARR: begin
        if (sts_i.out_free) begin
          cmd.emit = 1'b1;
          cmd.ch   = (state_q == ST_ENDREC) ? CH_BRACE : CH_CLOSE;
          cmd.last = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign cmd_o = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      seen_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      seen_q  <= seen_d;
    end
  end

endmodule

// ===== hdl/jrs_dp.sv =====
// Datapath of the JSON record serializer: item registers, bit-serial decimal
// converter, fragment and escape byte selection, output register. Depends on jrs_pkg.
module jrs_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [jrs_pkg::IN_DATA_W-1:0] s_tdata_i,
  input  jrs_pkg::cmd_t                 cmd_i,
  output jrs_pkg::sts_t                 sts_o,
  output logic                          m_tvalid_o,
  input  logic                          m_tready_i,
  output logic [7:0]                    m_tdata_o,
  output logic                          m_tlast_o
);
  import jrs_pkg::*;

  logic [NUM_W-1:0]        in_id, in_value;
  logic [7:0]              in_name;
  logic [NUM_W-1:0]        value_q;
  logic [7:0]              name_q;
  logic [5:0]              rom_ptr_q;
  logic [2:0]              esc_idx_q;
  logic [NUM_W-1:0]        bin_q;
  logic [BCD_DIGITS*4-1:0] bcd_q, bcd_adj;
  logic [5:0]              cnt_q;
  logic                    conv_id_q;
  logic [1:0]              mod3_q, mod3_d;
  logic [3:0]              dig_idx_q;
  logic                    started_q;
  logic [3:0]              digit;
  logic [7:0]              esc_src;
  logic [2:0]              esc_idx;
  logic [7:0]              byte_d;
  logic                    out_valid_q;
  logic [7:0]              byte_q;
  logic                    last_q;
  logic                    out_free;
  logic                    busy;

  assign in_id    = s_tdata_i[NUM_W-1:0];
  assign in_value = s_tdata_i[2*NUM_W-1:NUM_W];
  assign in_name  = s_tdata_i[2*NUM_W+7:2*NUM_W];

  assign busy     = (cnt_q != 6'd0);
  assign out_free = !out_valid_q || m_tready_i;
  assign digit    = bcd_q[{dig_idx_q, 2'b00} +: 4];
  assign esc_src  = cmd_i.esc_from_in ? in_name : name_q;
  assign esc_idx  = cmd_i.esc_from_in ? 3'd0 : esc_idx_q;

  // Add-3 correction of every BCD digit before the shift.
  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      bcd_adj[i*4 +: 4] = (bcd_q[i*4 +: 4] >= 4'd5) ? (bcd_q[i*4 +: 4] + 4'd3)
                                                     : bcd_q[i*4 +: 4];
    end
  end

  always_comb begin
    case ({mod3_q, bin_q[NUM_W-1]})
      3'b000, 3'b011: mod3_d = 2'd0;
      3'b001, 3'b100: mod3_d = 2'd1;
      default:        mod3_d = 2'd2;
    endcase
  end

  always_comb begin
    case (cmd_i.src)
      SRC_ROM:   byte_d = txt_byte(rom_ptr_q);
      SRC_DIGIT: byte_d = CH_ZERO + {4'd0, digit};
      SRC_ESC:   byte_d = esc_byte(esc_src, esc_idx);
      default:   byte_d = cmd_i.ch;
    endcase
  end

  always_comb begin
    sts_o             = '0;
    sts_o.out_free    = out_free;
    sts_o.in_plain    = (esc_len(in_name) == 3'd1);
    sts_o.rom_seg_end = is_seg_end(rom_ptr_q);
    sts_o.conv_done   = !busy;
    sts_o.dig_skip    = !started_q && (digit == 4'd0) && (dig_idx_q != 4'd0);
    sts_o.dig_last    = (dig_idx_q == 4'd0);
    sts_o.esc_last    = (esc_idx_q == esc_len(name_q) - 3'd1);
    sts_o.id_div3     = (mod3_q == 2'd0);
  end

  // Payload and datapath registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      value_q <= in_value;
      name_q  <= in_name;
    end
    if (cmd_i.rom_load) begin
      rom_ptr_q <= cmd_i.rom_addr;
    end else if (cmd_i.rom_step) begin
      rom_ptr_q <= rom_ptr_q + 6'd1;
    end
    if (cmd_i.esc_init) begin
      esc_idx_q <= 3'd1;
    end else if (cmd_i.esc_step) begin
      esc_idx_q <= esc_idx_q + 3'd1;
    end
    if (cmd_i.conv_start) begin
      bin_q     <= cmd_i.conv_sel_id ? in_id : value_q;
      bcd_q     <= '0;
      conv_id_q <= cmd_i.conv_sel_id;
      if (cmd_i.conv_sel_id) begin
        mod3_q <= 2'd0;
      end
      dig_idx_q <= DIG_TOP;
      started_q <= 1'b0;
    end else begin
      if (busy) begin
        {bcd_q, bin_q} <= {bcd_adj[BCD_DIGITS*4-2:0], bin_q, 1'b0};
        if (conv_id_q) begin
          mod3_q <= mod3_d;
        end
      end
      if (cmd_i.dig_step) begin
        dig_idx_q <= dig_idx_q - 4'd1;
        started_q <= started_q || (digit != 4'd0);
      end
    end
    if (cmd_i.emit) begin
      byte_q <= byte_d;
      last_q <= cmd_i.last;
    end
  end

  // Control registers: converter step count and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= 6'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.conv_start) begin
        cnt_q <= CONV_STEPS;
      end else if (busy) begin
        cnt_q <= cnt_q - 6'd1;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = byte_q;
  assign m_tlast_o  = last_q;

endmodule

// ===== hdl/json_record_serializer_core.sv =====
// Top level of the JSON record serializer: controller and datapath joined by
// command and status structs. Depends on jrs_pkg, jrs_ctrl and jrs_dp.
//
// The block turns a stream of record items into the bytes of a JSON array, one
// byte per output transfer, with tlast on the final byte produced by each input
// item. The first byte of an item is loaded into the output register at the edge
// that accepts its input transfer and is offered from the next cycle on. A new
// item is taken while the previous byte is leaving the output register, so plain
// name bytes pass at one per cycle while the output does not stall. An escaped
// name byte gives 2 or 6 bytes, an end of record 2 bytes and an end of array 1
// or 2 bytes. Each of the two numbers of a record header goes through a
// bit-serial binary-to-decimal converter, the id conversion starting when the
// header is accepted and the value conversion when the last id digit is sent.
// The controller then steps through each of the ten digit positions, skipping
// leading zeros and sending the rest, and sends every text byte in turn. The id
// mod 3 test rides along with the id conversion. Output stalls hold the byte
// sequence where it is while a running conversion carries on.
module json_record_serializer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  // record_id [31:0], record_value [63:32], name_byte [71:64]
  input  logic [71:0] s_tdata_i,
  // kind [1:0]
  input  logic [1:0]  s_tuser_i,
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  // text_byte [7:0]
  output logic [7:0]  m_tdata_o,
  // last_of_run
  output logic        m_tlast_o
);
  import jrs_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // The controller decides which byte goes out next and when.
  jrs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .kind_i     (s_tuser_i),
    .s_tready_o (s_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // The datapath holds the item, converts numbers and forms the bytes.
  jrs_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tdata_i  (s_tdata_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tlast_o  (m_tlast_o)
  );

  // An input transfer only happens when the output register can take a byte.
  a_accept_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_tvalid_i && s_tready_o) |-> (!m_tvalid_o || m_tready_i))
    else $error("input accepted while output register is blocked");

  // Every accepted item puts its first byte out in the next cycle.
  a_first_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_tvalid_i && s_tready_o) |=> m_tvalid_o)
    else $error("accepted item produced no first byte");

  // A name byte of 0x20 or above, other than quote and backslash, is copied through as a single closing byte.
  a_plain_name: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_tvalid_i && s_tready_o && (s_tuser_i == KIND_NAME) &&
     (s_tdata_i[71:64] >= 8'h20) && (s_tdata_i[71:64] != CH_QUOTE) &&
     (s_tdata_i[71:64] != CH_BSLASH))
    |=> (m_tlast_o && (m_tdata_o == $past(s_tdata_i[71:64]))))
    else $error("plain name byte not passed through");

endmodule
